// ===== rtl/core/ppd_pkg.sv =====
package ppd_pkg;

    localparam int CoordW = 32;
    localparam int DiffW  = 33;
    localparam int WideW  = 67;
    localparam int DistW  = 33;
    localparam int TBits  = 32;
    localparam int RootBits = 34;

    localparam logic [1:0] RegRefX  = 2'd0;
    localparam logic [1:0] RegRefY  = 2'd1;
    localparam logic [1:0] RegRefZ  = 2'd2;
    localparam logic [1:0] RegLimit = 2'd3;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_SQ     = 4'd2,
        OP_SPAN   = 4'd3,
        OP_DOT    = 4'd4,
        OP_DIVI   = 4'd5,
        OP_DIVS   = 4'd6,
        OP_FOOT   = 4'd7,
        OP_FDIFF  = 4'd8,
        OP_UPDATE = 4'd9,
        OP_ROOTI  = 4'd10,
        OP_ROOTS  = 4'd11,
        OP_SEED   = 4'd12,
        OP_FEND   = 4'd13,
        OP_FSTART = 4'd14,
        OP_COMMIT = 4'd15
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] lane;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic dot_le0;
        logic dot_ge;
        logic have_first;
    } t_sts;

endpackage

// ===== rtl/core/ppd_datapath.sv =====
module ppd_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppd_pkg::t_cmd         i_cmd,
    input  logic [31:0]           i_point_x,
    input  logic [31:0]           i_point_y,
    input  logic [31:0]           i_point_z,
    input  logic [31:0]           i_ref_x,
    input  logic [31:0]           i_ref_y,
    input  logic [31:0]           i_ref_z,
    input  logic [63:0]           i_limit,
    input  logic                  i_last,
    output ppd_pkg::t_sts         o_sts,
    output logic [32:0]           o_dist
);
    import ppd_pkg::*;

    logic signed [DiffW-1:0] r_px [3];
    logic signed [DiffW-1:0] r_pv [3];
    logic signed [DiffW-1:0] r_rf [3];
    logic signed [DiffW-1:0] r_ax [3];
    logic signed [DiffW-1:0] r_f  [3];
    logic [WideW-1:0] r_acc, r_pos, r_neg, r_span, r_rem;
    logic [TBits-1:0] r_t;
    logic [63:0] r_best;
    logic r_have, n_have;
    logic [RootBits-1:0] r_root;
    logic [5:0] r_cnt;
    logic [32:0] r_dist;

    // per-lane operands for the shared 33x33 multiplier
    logic signed [DiffW-1:0] a_s, b_s;
    logic [DiffW-1:0] a_m, b_m;
    logic [2*DiffW-1:0] prod;
    logic [1:0] ln;
    logic [WideW-1:0] rem2, q30w;
    logic [63:0] q30;
    logic [DiffW+1:0] foff;
    logic [67:0] rsq, rn;
    logic [RootBits-1:0] rc;

    assign ln = (i_cmd.lane[1:0] == 2'd3) ? 2'd0 : i_cmd.lane[1:0];

    always_comb begin
        a_s = '0;
        b_s = '0;
        unique case (i_cmd.op)
            OP_SQ, OP_SEED: begin
                a_s = r_f[ln];
                b_s = r_f[ln];
            end
            OP_SPAN: begin
                a_s = r_ax[ln];
                b_s = r_ax[ln];
            end
            OP_DOT: begin
                a_s = r_rf[ln] - r_pv[ln];
                b_s = r_ax[ln];
            end
            OP_FOOT: begin
                a_s = r_ax[ln];
                b_s = $signed({1'b0, r_t});
            end
            default: ;
        endcase
        a_m  = a_s[DiffW-1] ? DiffW'(-a_s) : a_s;
        b_m  = b_s[DiffW-1] ? DiffW'(-b_s) : b_s;
        prod = a_m * b_m;
        rem2 = {r_rem[WideW-2:0], 1'b0};
        q30w = r_acc >> 2;
        q30  = q30w[63:0];
        foff = (DiffW+2)'(prod[2*DiffW-1:32]) + (DiffW+2)'(prod[31]);
        rc   = r_root | (RootBits'(1) << r_cnt);
        rsq  = 68'(rc) * 68'(rc);
        rn   = {2'b00, r_best, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_best <= '1;
        end else begin
            r_have <= n_have;
            unique case (i_cmd.op)
                OP_COMMIT: begin
                    if (i_last) begin
                        r_best <= '1;
                    end
                end
                OP_UPDATE: begin
                    if (i_cmd.lane[0]) begin
                        r_best <= q30;
                    end else if (q30 < r_best) begin
                        r_best <= q30;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_have = r_have;
        if (i_cmd.op == OP_UPDATE && i_cmd.lane[0]) n_have = 1'b1;
        if (i_cmd.op == OP_COMMIT && i_last) n_have = 1'b0;
    end

    function automatic logic [WideW-1:0] r_span_next(input logic [2:0] l,
                                                     input logic [WideW-1:0] s,
                                                     input logic [2*DiffW-1:0] p);
        logic [WideW-1:0] b;
        b = (l[1:0] == 2'd0) ? '0 : s;
        return b + WideW'(p);
    endfunction

    // payload datapath
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_px[0] <= DiffW'($signed(i_point_x));
                r_px[1] <= DiffW'($signed(i_point_y));
                r_px[2] <= DiffW'($signed(i_point_z));
                r_rf[0] <= DiffW'($signed(i_ref_x));
                r_rf[1] <= DiffW'($signed(i_ref_y));
                r_rf[2] <= DiffW'($signed(i_ref_z));
                r_ax[0] <= DiffW'($signed(i_point_x)) - r_pv[0];
                r_ax[1] <= DiffW'($signed(i_point_y)) - r_pv[1];
                r_ax[2] <= DiffW'($signed(i_point_z)) - r_pv[2];
                r_f[0]  <= DiffW'($signed(i_point_x)) - DiffW'($signed(i_ref_x));
                r_f[1]  <= DiffW'($signed(i_point_y)) - DiffW'($signed(i_ref_y));
                r_f[2]  <= DiffW'($signed(i_point_z)) - DiffW'($signed(i_ref_z));
                r_acc <= '0;
                r_pos <= '0;
                r_neg <= '0;
            end
            OP_SQ, OP_SEED: begin
                r_acc <= r_acc + WideW'(prod);
            end
            OP_SPAN: begin
                r_span <= r_span_next(i_cmd.lane, r_span, prod);
            end
            OP_DOT: begin
                if (a_s[DiffW-1] != b_s[DiffW-1] && a_m != 0 && b_m != 0)
                    r_neg <= r_neg + WideW'(prod);
                else
                    r_pos <= r_pos + WideW'(prod);
            end
            OP_DIVI: begin
                r_rem <= r_pos - r_neg;
                r_t   <= '0;
            end
            OP_DIVS: begin
                if (rem2 >= r_span) begin
                    r_rem <= rem2 - r_span;
                    r_t   <= {r_t[TBits-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_t   <= {r_t[TBits-2:0], 1'b0};
                end
            end
            OP_FOOT: begin
                r_f[ln] <= (a_s[DiffW-1] ? DiffW'(-$signed(foff)) : DiffW'(foff))
                           + r_pv[ln] - r_rf[ln];
            end
            OP_FEND: begin
                for (int i = 0; i < 3; i++) r_f[i] <= r_px[i] - r_rf[i];
            end
            OP_FSTART: begin
                for (int i = 0; i < 3; i++) r_f[i] <= r_pv[i] - r_rf[i];
            end
            OP_FDIFF: begin
                r_acc <= '0;
            end
            OP_ROOTI: begin
                r_root <= '0;
                r_cnt  <= 6'(RootBits - 1);
            end
            OP_ROOTS: begin
                if (rsq <= rn) r_root <= rc;
                r_cnt <= r_cnt - 6'd1;
            end
            OP_COMMIT: begin
                for (int i = 0; i < 3; i++) r_pv[i] <= r_px[i];
                r_dist <= (r_root > RootBits'(34'h1FFFFFFFF)) ? 33'h1FFFFFFFF
                                                              : r_root[32:0];
            end
            default: ;
        endcase
    end

    logic [WideW-1:0] sq30;
    assign sq30 = r_span >> 2;

    assign o_sts.skip       = (sq30[63:0] <= i_limit);
    assign o_sts.dot_le0    = (r_pos <= r_neg);
    assign o_sts.dot_ge     = ((r_pos - r_neg) >= r_span);
    assign o_sts.have_first = r_have;
    assign o_dist = r_dist;

endmodule

// ===== rtl/core/ppd_ctrl.sv =====
module ppd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_last,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ppd_pkg::t_sts  i_sts,
    output ppd_pkg::t_cmd  o_cmd
);
    import ppd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SEED  = 12'b000000000010,
        S_SPAN  = 12'b000000000100,
        S_CHK   = 12'b000000001000,
        S_DOT   = 12'b000000010000,
        S_DIV   = 12'b000000100000,
        S_FOOT  = 12'b000001000000,
        S_FSQ   = 12'b000010000000,
        S_UPD   = 12'b000100000000,
        S_ROOT  = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic r_seed, n_seed;

    // the first cycle of S_OUT loads the result register; offer it after that
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT) && (r_cnt != 6'd62);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_seed  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seed  <= n_seed;
        end
    end

    // sequence one vertex through the shared datapath
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_seed  = r_seed;
        o_cmd.op   = OP_NONE;
        o_cmd.lane = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = OP_LOAD;
                n_cnt    = '0;
                n_seed   = !i_sts.have_first;
                n_state  = i_sts.have_first ? S_SPAN : S_SEED;
            end
            S_SEED: begin
                o_cmd.op   = OP_SEED;
                o_cmd.lane = 3'(r_cnt);
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == 6'd2) n_state = S_UPD;
            end
            S_SPAN: begin
                o_cmd.op   = OP_SPAN;
                o_cmd.lane = 3'(r_cnt);
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == 6'd2) begin
                    n_cnt   = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_sts.skip ? S_DONE : S_DOT;
            end
            S_DOT: begin
                o_cmd.op   = OP_DOT;
                o_cmd.lane = 3'(r_cnt);
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == 6'd2) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'd0) begin
                    if (i_sts.dot_le0) begin
                        o_cmd.op = OP_FSTART;
                        n_state  = S_FSQ;
                    end else if (i_sts.dot_ge) begin
                        o_cmd.op = OP_FEND;
                        n_state  = S_FSQ;
                    end else begin
                        o_cmd.op = OP_DIVI;
                        n_cnt    = 6'd1;
                    end
                end else begin
                    o_cmd.op = OP_DIVS;
                    n_cnt    = r_cnt + 6'd1;
                    if (r_cnt == 6'(TBits)) begin
                        n_cnt   = '0;
                        n_state = S_FOOT;
                    end
                end
            end
            S_FOOT: begin
                o_cmd.op   = OP_FOOT;
                o_cmd.lane = 3'(r_cnt);
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == 6'd2) n_state = S_FSQ;
            end
            S_FSQ: begin
                if (r_cnt != 6'd63) begin
                    o_cmd.op = OP_FDIFF;
                    n_cnt    = 6'd63;
                end else begin
                    o_cmd.op = OP_NONE;
                    n_cnt    = '0;
                    n_state  = S_SEED;
                end
            end
            S_UPD: begin
                o_cmd.op   = OP_UPDATE;
                o_cmd.lane = {2'b00, r_seed};
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_last) begin
                    o_cmd.op = OP_ROOTI;
                    n_cnt    = '0;
                    n_state  = S_ROOT;
                end else begin
                    o_cmd.op = OP_COMMIT;
                    n_state  = S_IDLE;
                end
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOTS;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == 6'(RootBits - 1)) begin
                    o_cmd.op = OP_ROOTS;
                    n_state  = S_OUT;
                    n_cnt    = 6'd62;
                end
            end
            S_OUT: begin
                if (r_cnt == 6'd62) begin
                    o_cmd.op = OP_COMMIT;
                    n_cnt    = '0;
                end else if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_FSQ && r_cnt == 6'd63) n_seed = 1'b0;
    end

endmodule

// ===== rtl/core/point_polyline_distance_core.sv =====
// Shortest distance from a programmed reference point to a 3D polyline fed one
// vertex per transfer (signed Q16.16). A vertex with i_last_point set produces one
// result on o_nearest_distance (unsigned Q17.16, saturating). One shared 33x33
// multiplier, a restoring divider and a 34-step root unit set the timing: a vertex
// is shortest when it is first or its segment is skipped, longer when the projection
// clamps to an end of the segment, and longest with the 32-step projection divide.
// A last vertex adds the square root and the result load, plus any stall on the
// output. Program the reference point and the degenerate limit only while idle.
module point_polyline_distance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic        i_last_point,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [32:0] o_nearest_distance
);
    import ppd_pkg::*;

    logic [31:0] r_ref_x, r_ref_y, r_ref_z;
    logic [63:0] r_limit;
    logic        r_last;
    logic [1:0]  reg_idx;
    logic        wr;
    t_cmd        cmd;
    t_sts        sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr      = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
            r_limit <= '0;
        end else if (wr) begin
            unique case (reg_idx)
                RegRefX:  r_ref_x <= pwdata[31:0];
                RegRefY:  r_ref_y <= pwdata[31:0];
                RegRefZ:  r_ref_z <= pwdata[31:0];
                RegLimit: r_limit <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegRefX:  prdata = {32'd0, r_ref_x};
            RegRefY:  prdata = {32'd0, r_ref_y};
            RegRefZ:  prdata = {32'd0, r_ref_z};
            RegLimit: prdata = r_limit;
            default:  prdata = '0;
        endcase
    end

    // hold the last flag for the vertex in flight
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_last <= i_last_point;
    end

    ppd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_last      (r_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ppd_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_ref_x   (r_ref_x),
        .i_ref_y   (r_ref_y),
        .i_ref_z   (r_ref_z),
        .i_limit   (r_limit),
        .i_last    (r_last),
        .o_sts     (sts),
        .o_dist    (o_nearest_distance)
    );

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready while result pending");
    a_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_out_valid) else $error("result too early");
    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && $past(o_out_valid)) |=> o_in_ready)
        else $error("no return to idle");

endmodule

// ===== verif/ppd_checker.sv =====
module ppd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic        i_last_point,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [32:0] i_nearest_distance,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_vertex_count,
    output int          o_result_count,
    output int          o_segment_count,
    output int          o_skip_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppd_pkg::*;

    typedef logic signed [127:0] t_wide;

    // programmed reference point and skip threshold
    logic signed [31:0] ref_x_q, ref_y_q, ref_z_q;
    logic [63:0]        skip_limit_q;

    // running polyline state
    longint      prev_x, prev_y, prev_z;
    logic [63:0] best_sq;
    logic        have_first;

    logic [32:0] distance_q[$];

    function automatic t_wide sum_of_squares(longint dx, longint dy, longint dz);
        t_wide a = dx;
        t_wide b = dy;
        t_wide c = dz;
        return a * a + b * b + c * c;
    endfunction

    // drop the two low fraction bits: Q.32 to Q34.30
    function automatic logic [63:0] to_q30(t_wide s);
        return s[65:2];
    endfunction

    // |a| * t rounded half away from zero, then signed like a
    function automatic longint foot_offset(longint a, logic [63:0] t);
        logic [127:0] m;
        logic [127:0] mag;
        longint       q;
        mag = (a < 0) ? -a : a;
        m   = mag * t;
        q   = longint'(m[127:32] + m[31]);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic [32:0] floor_root(logic [63:0] q30);
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] c;
        n = {q30, 2'b00};
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) r = c;
        end
        return (r > 128'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : r[32:0];
    endfunction

    // fold one segment from the previous vertex into the running minimum
    task automatic measure_segment(longint px, longint py, longint pz,
                                   longint rx, longint ry, longint rz);
        longint      ax, ay, az, fx, fy, fz;
        t_wide       span, dot, sx, sy, sz;
        logic [63:0] t, d;
        ax = px - prev_x;
        ay = py - prev_y;
        az = pz - prev_z;
        span = sum_of_squares(ax, ay, az);
        o_segment_count++;
        if (to_q30(span) <= skip_limit_q) begin
            o_skip_count++;
            return;
        end
        sx = rx - prev_x;
        sy = ry - prev_y;
        sz = rz - prev_z;
        dot = sx * t_wide'(ax) + sy * t_wide'(ay) + sz * t_wide'(az);
        if (dot <= 0) begin
            fx = prev_x; fy = prev_y; fz = prev_z;
        end else if (dot >= span) begin
            fx = px; fy = py; fz = pz;
        end else begin
            t  = 64'((dot <<< 32) / span);
            fx = prev_x + foot_offset(ax, t);
            fy = prev_y + foot_offset(ay, t);
            fz = prev_z + foot_offset(az, t);
        end
        d = to_q30(sum_of_squares(fx - rx, fy - ry, fz - rz));
        if (d < best_sq) best_sq = d;
    endtask

    task automatic take_vertex();
        longint px, py, pz, rx, ry, rz;
        px = longint'($signed(i_point_x));
        py = longint'($signed(i_point_y));
        pz = longint'($signed(i_point_z));
        rx = longint'(ref_x_q);
        ry = longint'(ref_y_q);
        rz = longint'(ref_z_q);
        if (!have_first) begin
            best_sq    = to_q30(sum_of_squares(px - rx, py - ry, pz - rz));
            have_first = 1'b1;
        end else begin
            measure_segment(px, py, pz, rx, ry, rz);
        end
        prev_x = px; prev_y = py; prev_z = pz;
        if (i_last_point) begin
            distance_q = {distance_q, floor_root(best_sq)};
            have_first = 1'b0;
            best_sq    = '1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ref_x_q = '0; ref_y_q = '0; ref_z_q = '0;
            skip_limit_q = '0;
            prev_x = 0; prev_y = 0; prev_z = 0;
            best_sq = '1;
            have_first = 1'b0;
            distance_q.delete();
            o_fail_count    = 0;
            o_vertex_count  = 0;
            o_result_count  = 0;
            o_segment_count = 0;
            o_skip_count    = 0;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    RegRefX:  ref_x_q = pwdata[31:0];
                    RegRefY:  ref_y_q = pwdata[31:0];
                    RegRefZ:  ref_z_q = pwdata[31:0];
                    RegLimit: skip_limit_q = pwdata;
                    default: ;
                endcase
            end
            // compare a result transfer against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (distance_q.size() == 0) begin
                    $error("nearest_distance: unexpected result %0d", i_nearest_distance);
                    o_fail_count++;
                end else if (distance_q[0] !== i_nearest_distance) begin
                    $error("nearest_distance: expected %0d, actual %0d",
                           distance_q[0], i_nearest_distance);
                    o_fail_count++;
                    void'(distance_q.pop_front());
                end else begin
                    void'(distance_q.pop_front());
                end
            end
            // predict from an input transfer
            if (i_in_valid && i_in_ready) begin
                o_vertex_count++;
                take_vertex();
            end
        end
        o_pending = distance_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ppd_pkg::*;

    localparam logic [31:0] ONE       = 32'h0001_0000;
    localparam int          TIMEOUT   = 1_500_000;
    localparam int          SETTLE    = 150;
    localparam int          PHASE_LEN = 235;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_point_x, i_point_y, i_point_z;
    logic        i_last_point;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [32:0] o_nearest_distance;

    int fail_count, pending, vertex_count, result_count, segment_count, skip_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_taken;
    int hold_cycles;
    int cycle_count;
    int config_count;
    int phase_items;

    logic [31:0] cur_ref[3];

    point_polyline_distance_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_point_z          (i_point_z),
        .i_last_point       (i_last_point),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_nearest_distance (o_nearest_distance)
    );

    ppd_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_point_z          (i_point_z),
        .i_last_point       (i_last_point),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_nearest_distance (o_nearest_distance),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_vertex_count     (vertex_count),
        .o_result_count     (result_count),
        .o_segment_count    (segment_count),
        .o_skip_count       (skip_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // abort a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= TIMEOUT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL point_polyline_distance_core");
                $finish;
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        hold_cycles = 0;
        hold_taken  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_taken) begin
                hold_taken  = hold_requests;
                hold_cycles = 600;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_count++;
    endtask

    task automatic set_reference(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [63:0] limit);
        reg_write(RegRefX, {32'd0, x});
        reg_write(RegRefY, {32'd0, y});
        reg_write(RegRefZ, {32'd0, z});
        reg_write(RegLimit, limit);
        cur_ref[0] = x;
        cur_ref[1] = y;
        cur_ref[2] = z;
    endtask

    // offer one vertex, idling first at random; return after its transfer
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_point_z    <= z;
        i_last_point <= last;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        phase_items++;
    endtask

    // drain all results, then let any segment still in flight finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord(int axis);
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom();
            3:       return cur_ref[axis];
            4, 5:    return cur_ref[axis] + 32'($signed($urandom_range(8 * ONE)) - 4 * ONE);
            default: return cur_ref[axis] + 32'($signed($urandom_range(64 * ONE)) - 32 * ONE);
        endcase
    endfunction

    // a polyline of random length; sometimes repeat a vertex to hit the skip path
    task automatic send_polyline();
        int          n;
        logic [31:0] x, y, z;
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
        for (int k = 0; k < n; k++) begin
            if (k == 0 || $urandom_range(7) != 0) begin
                x = pick_coord(0);
                y = pick_coord(1);
                z = pick_coord(2);
            end else if ($urandom_range(1) == 0) begin
                x = x + $urandom_range(3);
            end
            send_vertex(x, y, z, k == n - 1);
        end
        // occasional stray noise: a lone first vertex closed at once
        if ($urandom_range(15) == 0) send_vertex($urandom(), $urandom(), $urandom(), 1'b1);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit long_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_items    = 0;
        if (long_hold) hold_requests++;
        while (phase_items < PHASE_LEN) send_polyline();
        wait_idle();
    endtask

    initial begin
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_last_point = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_requests = 0;
        config_count = 0;
        cur_ref[0] = '0; cur_ref[1] = '0; cur_ref[2] = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single vertices at the extremes, reference at reset origin
        send_vertex('0, '0, '0, 1'b1);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        // projection inside, before the start, past the end
        send_vertex(-ONE, ONE, '0, 1'b0);
        send_vertex(ONE, ONE, ONE, 1'b1);
        send_vertex(ONE, '0, '0, 1'b0);
        send_vertex(2 * ONE, '0, '0, 1'b1);
        send_vertex(2 * ONE, ONE, '0, 1'b0);
        send_vertex(ONE, 32'h0000_8000, '0, 1'b1);
        // zero-length segment, then a zig-zag with odd fractions
        send_vertex(3 * ONE, 3 * ONE, 3 * ONE, 1'b0);
        send_vertex(3 * ONE, 3 * ONE, 3 * ONE, 1'b1);
        send_vertex(32'h0003_1234, -32'h0002_0001, 32'h0000_0007, 1'b0);
        send_vertex(-32'h0001_5555, 32'h0004_0003, -32'h0000_0009, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // short segments skipped, including a skipped final one
        set_reference(ONE, -ONE, 32'h0000_4000, 64'd4 << 30);
        send_vertex(5 * ONE, '0, '0, 1'b0);
        send_vertex(6 * ONE, '0, '0, 1'b1);
        send_vertex('0, '0, '0, 1'b0);
        send_vertex(10 * ONE, '0, '0, 1'b0);
        send_vertex(10 * ONE, ONE, '0, 1'b1);
        wait_idle();
        // everything skipped
        set_reference(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1);
        send_vertex(32'h8000_0000, '0, '0, 1'b0);
        send_vertex(32'h7FFF_FFFF, '0, '0, 1'b1);
        wait_idle();

        // random phases, each with its own reference and threshold
        set_reference($urandom_range(ONE), -$urandom_range(ONE), '0, '0);
        run_phase(0, 0, 1'b0);
        set_reference(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      {32'd0, $urandom()});
        run_phase(87, 0, 1'b0);
        set_reference(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      64'($urandom_range(16)) << 30);
        run_phase(0, 87, 1'b1);
        set_reference($urandom(), $urandom(), $urandom(), {$urandom(), $urandom()} >> 40);
        run_phase(13, 13, 1'b0);
        set_reference($urandom(), $urandom(), $urandom(), '0);
        run_phase(0, 0, 1'b1);

        $display("covered %0d vertices, %0d distances, %0d segments (%0d skipped)",
                 vertex_count, result_count, segment_count, skip_count);
        $display("%0d register writes across 7 settings, %0d mismatches",
                 config_count, fail_count);
        if (fail_count == 0) begin
            $display("PASS point_polyline_distance_core");
        end else begin
            $display("FAIL point_polyline_distance_core");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ppd_pkg.sv
rtl/core/ppd_datapath.sv
rtl/core/ppd_ctrl.sv
rtl/core/point_polyline_distance_core.sv
verif/ppd_checker.sv
verif/tb_top.sv
